/* rtl/set_assoc_cache_lru_lookup_macros.svh */
// Assertion macros shared by the cache lookup RTL.
// Bodies are empty when SYNTHESIS is defined.
`ifndef SET_ASSOC_CACHE_LRU_LOOKUP_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_LOOKUP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SCAL_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define SCAL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SCAL_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define SCAL_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/scal_pkg.sv */
// Package for the set-associative cache lookup: sizes, codes, set row layout,
// request/result structs and the LRU compare helper. No dependencies.
`default_nettype none

package scal_pkg;

  localparam int MAX_SET_BITS = 6;
  localparam int SET_W        = MAX_SET_BITS;
  localparam int NUM_SETS     = 1 << MAX_SET_BITS;
  localparam int MAX_WAYS     = 8;
  localparam int WAY_W        = $clog2(MAX_WAYS);
  localparam int NW_W         = WAY_W + 1;
  localparam int ADDR_W       = 64;
  localparam int TAG_W        = 64;
  localparam int STAMP_W      = 64;
  localparam int CNT_W        = 32;
  localparam int SB_W         = 3;
  localparam int WAYS_W       = 4;
  localparam int BB_W         = 6;
  localparam int TSH_W        = BB_W + 1;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 6;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_STORE  = 2'd1;
  localparam logic [1:0] CMD_MODIFY = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd2;

  typedef struct packed {
    logic [MAX_WAYS-1:0]              valid;
    logic [MAX_WAYS-1:0][TAG_W-1:0]   tag;
    logic [MAX_WAYS-1:0][STAMP_W-1:0] stamp;
  } row_t;

  typedef struct packed {
    logic              launch;
    logic [NW_W-1:0]   nw;
    logic [TAG_W-1:0]  tag;
  } vic_req_t;

  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic             has_empty;
    logic [WAY_W-1:0] empty_way;
    logic [WAY_W-1:0] lru_way;
  } vic_res_t;

  typedef struct packed {
    logic               act;
    logic [STAMP_W-1:0] stamp;
    logic [WAY_W-1:0]   way;
  } node_t;

  // older of two candidates; left wins ties, an inactive one never beats an active one
  function automatic node_t lru_pick(node_t a, node_t b);
    return (b.act && (!a.act || (b.stamp < a.stamp))) ? b : a;
  endfunction

endpackage

`default_nettype wire

/* rtl/scal_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module scal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/scal_victim.sv */
// Way selection for one set row: tag match, first empty way and an oldest-stamp
// tree with each tree level registered. Uses scal_pkg.
`default_nettype none

module scal_victim (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire scal_pkg::vic_req_t req,
  input  wire scal_pkg::row_t     row,
  output      scal_pkg::vic_res_t res
);

  typedef struct packed {
    logic                       hit;
    logic [scal_pkg::WAY_W-1:0] hit_way;
    logic                       has_empty;
    logic [scal_pkg::WAY_W-1:0] empty_way;
  } info_t;

  logic [scal_pkg::MAX_WAYS-1:0] act;
  logic [scal_pkg::MAX_WAYS-1:0] match;
  logic [scal_pkg::MAX_WAYS-1:0] empty;
  scal_pkg::node_t leaf [scal_pkg::MAX_WAYS];
  info_t info0;

  scal_pkg::node_t lvl_q [1:scal_pkg::WAY_W][scal_pkg::MAX_WAYS/2];
  info_t info_q [1:scal_pkg::WAY_W];
  logic [scal_pkg::WAY_W:1] vld_q;

  for (genvar w = 0; w < scal_pkg::MAX_WAYS; w++) begin : g_way
    assign act[w]   = scal_pkg::NW_W'(w) < req.nw;
    assign match[w] = act[w] && row.valid[w] && (row.tag[w] == req.tag);
    assign empty[w] = act[w] && !row.valid[w];
    assign leaf[w]  = '{act: act[w], stamp: row.stamp[w], way: scal_pkg::WAY_W'(w)};
  end

  always_comb begin
    info0.hit       = |match;
    info0.has_empty = |empty;
    info0.hit_way   = '0;
    info0.empty_way = '0;
    for (int i = scal_pkg::MAX_WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        info0.hit_way = scal_pkg::WAY_W'(i);
      end
      if (empty[i]) begin
        info0.empty_way = scal_pkg::WAY_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < scal_pkg::MAX_WAYS / 2; i++) begin
      lvl_q[1][i] <= scal_pkg::lru_pick(leaf[2*i], leaf[2*i+1]);
    end
    for (int l = 2; l <= scal_pkg::WAY_W; l++) begin
      for (int i = 0; i < (scal_pkg::MAX_WAYS >> l); i++) begin
        lvl_q[l][i] <= scal_pkg::lru_pick(lvl_q[l-1][2*i], lvl_q[l-1][2*i+1]);
      end
    end
    info_q[1] <= info0;
    for (int l = 2; l <= scal_pkg::WAY_W; l++) begin
      info_q[l] <= info_q[l-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else begin
      vld_q[1] <= req.launch;
      for (int l = 2; l <= scal_pkg::WAY_W; l++) begin
        vld_q[l] <= vld_q[l-1];
      end
    end
  end

  assign res.valid     = vld_q[scal_pkg::WAY_W];
  assign res.hit       = info_q[scal_pkg::WAY_W].hit;
  assign res.hit_way   = info_q[scal_pkg::WAY_W].hit_way;
  assign res.has_empty = info_q[scal_pkg::WAY_W].has_empty;
  assign res.empty_way = info_q[scal_pkg::WAY_W].empty_way;
  assign res.lru_way   = lvl_q[scal_pkg::WAY_W][0].way;

endmodule

`default_nettype wire

/* rtl/set_assoc_cache_lru_lookup.sv */
// Top level of the set-associative cache tag and LRU replacement engine.
// Uses scal_pkg, scal_ram, scal_victim and set_assoc_cache_lru_lookup_macros.svh.
//
// Usage:
//   A request (cmd, address) is taken at a clock edge with start high and busy
//   low. Load and store make one access, modify makes two, cmd 3 is taken and
//   dropped without a result and without raising busy.
//   Each access yields one result, shown for exactly one cycle with done high;
//   last marks the final result of a request. The receiver cannot stall.
//   Steps: an access goes through address shift, set row read from the set
//   RAM, three levels of the oldest-stamp tree, then the row write-back; modify
//   runs these steps twice. A new request can be taken in the cycle done is
//   high. The set RAM holds one row per set; a row is read once and written once
//   per access, so accesses never overlap.
//   Configuration (wr_en, wr_index, wr_data) must be written with busy low; not enforced.
//   Reset: config returns to set_bits 0, ways 1, block_bits 0; totals, stamp
//   and per-set row-valid flags clear at once, no clearing pass.
`default_nettype none
`include "set_assoc_cache_lru_lookup_macros.svh"

module set_assoc_cache_lru_lookup (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output      logic                              busy,
  input  wire logic [1:0]                        cmd,
  input  wire logic [scal_pkg::ADDR_W-1:0]       address,
  input  wire logic                              wr_en,
  input  wire logic [scal_pkg::CFG_IDX_W-1:0]    wr_index,
  input  wire logic [scal_pkg::CFG_DATA_W-1:0]   wr_data,
  output      logic                              done,
  output      logic                              hit,
  output      logic                              evicted,
  output      logic [scal_pkg::WAY_W-1:0]        way_used,
  output      logic [scal_pkg::CNT_W-1:0]        hit_total,
  output      logic [scal_pkg::CNT_W-1:0]        miss_total,
  output      logic [scal_pkg::CNT_W-1:0]        evict_total,
  output      logic                              last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADDR = 2'd1;
  localparam logic [1:0] S_LOOK = 2'd2;
  localparam logic [1:0] S_WAIT = 2'd3;

  logic [1:0] state;

  logic [scal_pkg::SB_W-1:0]   cfg_set_bits;
  logic [scal_pkg::WAYS_W-1:0] cfg_ways;
  logic [scal_pkg::BB_W-1:0]   cfg_block_bits;

  logic [scal_pkg::ADDR_W-1:0]  addr_q;
  logic                         second_q;
  logic [scal_pkg::SET_W-1:0]   set_q;
  logic [scal_pkg::TAG_W-1:0]   tag_q;
  logic [scal_pkg::NUM_SETS-1:0] row_valid;

  logic [scal_pkg::STAMP_W-1:0] stamp;
  logic [scal_pkg::STAMP_W-1:0] stamp_next;
  logic [scal_pkg::CNT_W-1:0]   hits_seen;
  logic [scal_pkg::CNT_W-1:0]   misses_seen;
  logic [scal_pkg::CNT_W-1:0]   evictions_seen;

  logic [scal_pkg::SB_W-1:0]   sb_eff;
  logic [scal_pkg::NW_W-1:0]   nw_eff;
  logic [scal_pkg::ADDR_W-1:0] blk_shift;
  logic [scal_pkg::SET_W-1:0]  set_mask;
  logic [scal_pkg::SET_W-1:0]  set_calc;
  logic [scal_pkg::TSH_W-1:0]  tag_sh;
  logic [scal_pkg::TAG_W-1:0]  tag_calc;

  scal_pkg::row_t     rd_row;
  scal_pkg::row_t     row_eff;
  scal_pkg::row_t     row_new;
  scal_pkg::vic_req_t vreq;
  scal_pkg::vic_res_t vres;

  logic                       ram_we;
  logic                       ram_re;
  logic [scal_pkg::WAY_W-1:0] used;
  logic                       evict;

  assign busy = (state != S_IDLE);

  // effective configuration
  always_comb begin
    if (int'(cfg_set_bits) > scal_pkg::MAX_SET_BITS) begin
      sb_eff = scal_pkg::SB_W'(scal_pkg::MAX_SET_BITS);
    end else begin
      sb_eff = cfg_set_bits;
    end
    if (cfg_ways == '0) begin
      nw_eff = scal_pkg::NW_W'(1);
    end else if (int'(cfg_ways) > scal_pkg::MAX_WAYS) begin
      nw_eff = scal_pkg::NW_W'(scal_pkg::MAX_WAYS);
    end else begin
      nw_eff = scal_pkg::NW_W'(cfg_ways);
    end
  end

  assign blk_shift = addr_q >> cfg_block_bits;
  assign set_mask  = ~({scal_pkg::SET_W{1'b1}} << sb_eff);
  assign set_calc  = scal_pkg::SET_W'(blk_shift) & set_mask;
  assign tag_sh    = scal_pkg::TSH_W'(sb_eff) + scal_pkg::TSH_W'(cfg_block_bits);
  assign tag_calc  = tag_sh[scal_pkg::TSH_W-1] ? '0
                                               : (addr_q >> tag_sh[scal_pkg::BB_W-1:0]);

  assign ram_re = (state == S_ADDR);
  assign ram_we = (state == S_WAIT) && vres.valid;

  scal_ram #(
    .WIDTH ($bits(scal_pkg::row_t)),
    .DEPTH (scal_pkg::NUM_SETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (set_q),
    .wdata (row_new),
    .re    (ram_re),
    .raddr (set_calc),
    .rdata (rd_row)
  );

  // a set never written reads as all invalid with zero stamps
  always_comb begin
    row_eff = rd_row;
    if (!row_valid[set_q]) begin
      row_eff.valid = '0;
      row_eff.stamp = '0;
    end
  end

  assign vreq.launch = (state == S_LOOK);
  assign vreq.nw     = nw_eff;
  assign vreq.tag    = tag_q;

  scal_victim u_victim (
    .clk (clk),
    .rst (rst),
    .req (vreq),
    .row (row_eff),
    .res (vres)
  );

  assign stamp_next = stamp + 1'b1;

  always_comb begin
    evict = 1'b0;
    priority if (vres.hit) begin
      used = vres.hit_way;
    end else if (vres.has_empty) begin
      used = vres.empty_way;
    end else begin
      used  = vres.lru_way;
      evict = 1'b1;
    end
    row_new             = row_eff;
    row_new.valid[used] = 1'b1;
    row_new.tag[used]   = tag_q;
    row_new.stamp[used] = stamp_next;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      second_q       <= 1'b0;
      done           <= 1'b0;
      cfg_set_bits   <= '0;
      cfg_ways       <= scal_pkg::WAYS_W'(1);
      cfg_block_bits <= '0;
      row_valid      <= '0;
      stamp          <= '0;
      hits_seen      <= '0;
      misses_seen    <= '0;
      evictions_seen <= '0;
    end else begin
      done <= 1'b0;
      if (wr_en) begin
        unique case (wr_index)
          scal_pkg::REG_SET_BITS:   cfg_set_bits   <= wr_data[scal_pkg::SB_W-1:0];
          scal_pkg::REG_WAYS:       cfg_ways       <= wr_data[scal_pkg::WAYS_W-1:0];
          scal_pkg::REG_BLOCK_BITS: cfg_block_bits <= wr_data[scal_pkg::BB_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start && (cmd != scal_pkg::CMD_NONE)) begin
            second_q <= (cmd == scal_pkg::CMD_MODIFY);
            state    <= S_ADDR;
          end
        end
        S_ADDR: state <= S_LOOK;
        S_LOOK: state <= S_WAIT;
        S_WAIT: begin
          if (vres.valid) begin
            stamp            <= stamp_next;
            row_valid[set_q] <= 1'b1;
            done             <= 1'b1;
            if (vres.hit) begin
              hits_seen <= hits_seen + 1'b1;
            end else begin
              misses_seen <= misses_seen + 1'b1;
            end
            if (evict) begin
              evictions_seen <= evictions_seen + 1'b1;
            end
            if (second_q) begin
              second_q <= 1'b0;
              state    <= S_ADDR;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && start) begin
      addr_q <= address;
    end
    if (state == S_ADDR) begin
      set_q <= set_calc;
      tag_q <= tag_calc;
    end
    if (ram_we) begin
      hit      <= vres.hit;
      evicted  <= evict;
      way_used <= used;
      last     <= !second_q;
    end
  end

  assign hit_total   = hits_seen;
  assign miss_total  = misses_seen;
  assign evict_total = evictions_seen;

  `SCAL_ASSERT_IMPL(a_done_after_wait, clk, rst, done, $past(state) == S_WAIT, "done without write-back")
  `SCAL_ASSERT_IMPL(a_victim_in_wait, clk, rst, vres.valid, state == S_WAIT, "way result outside wait")
  `SCAL_ASSERT_IMPL(a_hit_no_evict, clk, rst, done, !(hit && evicted), "hit reported with eviction")
  `SCAL_ASSERT_NEXT(a_row_marked, clk, rst, ram_we, row_valid[set_q], "written set not marked valid")
  `SCAL_ASSERT_IMPL(a_second_busy, clk, rst, second_q, busy, "pending second access while idle")

endmodule

`default_nettype wire
